// ----- hw/rtl/sirz_pkg.sv -----
// Shared widths, codes and constants of the square image rotate and zoom block.
package sirz_pkg;

  localparam int MAX_SIDE  = 32;
  localparam int IDX_W     = $clog2(MAX_SIDE);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);

  // Fixed field widths
  localparam int ROW_W     = 5;
  localparam int PIX_W     = 8;
  localparam int CSIDE_W   = 6;
  localparam int ROT_W     = 2;
  localparam int ZOOM_W    = 12;
  localparam int FRAC_W    = 8;
  localparam int OSIDE_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  // Divider: dividend is row scaled by the fractional width
  localparam int DIVD_W    = ROW_W + FRAC_W;
  localparam int PROD_W    = SIDE_W + ZOOM_W;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM = 2'd2;

  // Clockwise quarter turns
  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  // Reset values of the registers
  localparam logic [CSIDE_W-1:0] SIDE_RST = 6'd32;
  localparam logic [ROT_W-1:0]   ROT_RST  = ROT_0;
  localparam logic [ZOOM_W-1:0]  ZOOM_RST = 12'd256;

endpackage

// ----- hw/rtl/sirz_in_if.sv -----
// Request channel: pixel write or output pixel read.
interface sirz_in_if import sirz_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] col;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, req_type, row, col, pixel_value, input ready);
  modport sink   (input valid, req_type, row, col, pixel_value, output ready);
endinterface

// ----- hw/rtl/sirz_out_if.sv -----
// Result channel: pixel data, range flag and output side.
interface sirz_out_if import sirz_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   read_data;
  logic               in_range;
  logic [OSIDE_W-1:0] out_side;

  modport source (output valid, read_data, in_range, out_side, input ready);
  modport sink   (input valid, read_data, in_range, out_side, output ready);
endinterface

// ----- hw/rtl/sirz_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface sirz_cfg_if import sirz_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ----- hw/rtl/square_image_rotate_zoom.sv -----
// Square image store with quarter-turn rotation and nearest-neighbour zoom on read.
//
//  channel   dir  word                                    handshake
//  in_chan   in   req_type, row, col, pixel_value         valid / ready
//  out_chan  out  read_data, in_range, out_side           valid / ready
//  cfg_chan  in   addr (register index), data             valid / ready (always ready)
//
// A write, or a read outside the output image, passes from acceptance through
// decode and finish to its result; a read inside the output image passes through
// decode, the divider, rotate, memory read and finish, the bit-serial divider
// yielding both source indexes, one quotient bit a cycle. One word is in flight
// at a time; the next is taken in idle once the result is parked.
// Reset (rst_n, synchronous) clears control and configuration; the pixel store
// is not cleared and needs no clearing pass. A stalled result holds its word;
// one more request is still taken and waits in finish, and no further request
// is taken until the stalled word leaves.
module square_image_rotate_zoom import sirz_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  sirz_in_if.sink    in_chan,
  sirz_out_if.source out_chan,
  sirz_cfg_if.sink   cfg_chan
);

  localparam int CNT_W = $clog2(IDX_W + 1);
  localparam int ST_W  = 3;

  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_PREP = 3'd1;
  localparam logic [ST_W-1:0] ST_DIV  = 3'd2;
  localparam logic [ST_W-1:0] ST_ROT  = 3'd3;
  localparam logic [ST_W-1:0] ST_MEM  = 3'd4;
  localparam logic [ST_W-1:0] ST_FIN  = 3'd5;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CSIDE_W-1:0] side_r;
  logic [ROT_W-1:0]   rot_r;
  logic [ZOOM_W-1:0]  zoom_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RST;
      rot_r  <= ROT_RST;
      zoom_r <= ZOOM_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.addr)
        CFG_SIDE: side_r <= cfg_chan.data[CSIDE_W-1:0];
        CFG_ROT:  rot_r  <= cfg_chan.data[ROT_W-1:0];
        CFG_ZOOM: zoom_r <= cfg_chan.data[ZOOM_W-1:0];
        default:  ;
      endcase
    end
  end

  // Stored side saturates to the store size
  logic [SIDE_W-1:0] eff_side;
  assign eff_side = (32'(side_r) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(side_r);

  // ---------------------------------------------------------------------------
  // Sequencer and item registers
  // ---------------------------------------------------------------------------
  logic [ST_W-1:0]    state_r, state_nxt;
  logic               req_r;
  logic [ROW_W-1:0]   row_r, col_r;
  logic [PIX_W-1:0]   pix_r;
  logic [SIDE_W-1:0]  oside_r, oside_nxt;
  logic               inr_r, inr_nxt;
  logic               hit_r, hit_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // Two divider lanes: lane 0 row, lane 1 column
  logic [ZOOM_W-1:0]  rem_r [2];
  logic [ZOOM_W-1:0]  rem_nxt [2];
  logic [IDX_W-1:0]   quo_r [2];
  logic [IDX_W-1:0]   quo_nxt [2];

  logic [ADDR_W-1:0]  raddr_r, raddr_nxt;
  logic [PIX_W-1:0]   rdata_r;

  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   out_data_r, out_data_nxt;
  logic               out_inr_r, out_inr_nxt;
  logic [SIDE_W-1:0]  out_side_r, out_side_nxt;

  logic               in_fire;
  logic               mem_we;
  logic [ADDR_W-1:0]  waddr;
  logic               mem_re;

  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  osd_full;
  logic [SIDE_W-1:0]  osd;

  logic [DIVD_W-1:0]  divd [2];
  logic [SIDE_W-1:0]  last_idx;
  logic [IDX_W-1:0]   sr, sc, flip_i, flip_j;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Output side: floor(side * zoom) in Q4.8, saturated
  assign prod     = PROD_W'(eff_side) * PROD_W'(zoom_r);
  assign osd_full = prod >> FRAC_W;
  assign osd      = (osd_full > PROD_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(osd_full);

  assign divd[0] = {row_r, {FRAC_W{1'b0}}};
  assign divd[1] = {col_r, {FRAC_W{1'b0}}};

  // Rotation map from the scaled output indexes
  assign last_idx = eff_side - SIDE_W'(1);
  assign flip_i   = IDX_W'(last_idx - SIDE_W'(quo_r[0]));
  assign flip_j   = IDX_W'(last_idx - SIDE_W'(quo_r[1]));

  always_comb begin
    unique case (rot_r)
      ROT_90:  begin sr = flip_j;   sc = quo_r[0]; end
      ROT_180: begin sr = flip_i;   sc = flip_j;   end
      ROT_270: begin sr = quo_r[1]; sc = flip_i;   end
      default: begin sr = quo_r[0]; sc = quo_r[1]; end
    endcase
  end

  // One restoring step: bring in the next dividend bit, subtract if it fits
  function automatic logic [ZOOM_W:0] div_trial(input logic [ZOOM_W-1:0] rem,
                                                input logic             bit_in,
                                                input logic [ZOOM_W-1:0] dsr);
    logic [ZOOM_W:0] t;
    t = {rem, bit_in};
    div_trial = t - {1'b0, dsr};
  endfunction

  always_comb begin
    logic [ZOOM_W:0] t;
    logic [ZOOM_W:0] d;
    t             = '0;
    d             = '0;
    state_nxt     = state_r;
    oside_nxt     = oside_r;
    inr_nxt       = inr_r;
    hit_nxt       = hit_r;
    cnt_nxt       = cnt_r;
    raddr_nxt     = raddr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_inr_nxt   = out_inr_r;
    out_side_nxt  = out_side_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    waddr         = {IDX_W'(row_r), IDX_W'(col_r)};

    // Drop the result word once taken
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        oside_nxt = osd;
        cnt_nxt   = '0;
        for (int k = 0; k < 2; k++) begin
          rem_nxt[k] = ZOOM_W'(divd[k] >> IDX_W);
          quo_nxt[k] = divd[k][IDX_W-1:0];
        end
        if (req_r == REQ_WRITE) begin
          inr_nxt   = 1'b1;
          hit_nxt   = 1'b0;
          mem_we    = (32'(row_r) < MAX_SIDE) && (32'(col_r) < MAX_SIDE);
          state_nxt = ST_FIN;
        end else if ((SIDE_W'(row_r) < osd) && (SIDE_W'(col_r) < osd) && (zoom_r != '0)) begin
          inr_nxt   = 1'b1;
          hit_nxt   = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          inr_nxt   = 1'b0;
          hit_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end
      end
      ST_DIV: begin
        for (int k = 0; k < 2; k++) begin
          t = {rem_r[k], quo_r[k][IDX_W-1]};
          d = div_trial(rem_r[k], quo_r[k][IDX_W-1], zoom_r);
          if (t >= {1'b0, zoom_r}) begin
            rem_nxt[k] = ZOOM_W'(d);
            quo_nxt[k] = IDX_W'({quo_r[k], 1'b1});
          end else begin
            rem_nxt[k] = ZOOM_W'(t);
            quo_nxt[k] = IDX_W'({quo_r[k], 1'b0});
          end
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(IDX_W - 1)) begin
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        raddr_nxt = {sr, sc};
        state_nxt = ST_MEM;
      end
      ST_MEM: begin
        mem_re    = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // Park the word once the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = hit_r ? rdata_r : '0;
          out_inr_nxt   = inr_r;
          out_side_nxt  = oside_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      inr_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      hit_r       <= hit_nxt;
      inr_r       <= inr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_chan.req_type;
      row_r <= in_chan.row;
      col_r <= in_chan.col;
      pix_r <= in_chan.pixel_value;
    end
    oside_r    <= oside_nxt;
    raddr_r    <= raddr_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    out_data_r <= out_data_nxt;
    out_inr_r  <= out_inr_nxt;
    out_side_r <= out_side_nxt;
  end

  // ---------------------------------------------------------------------------
  // Pixel store: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] pixel_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pixel_mem[waddr] <= pix_r;
    end
    if (mem_re) begin
      rdata_r <= pixel_mem[raddr_r];
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_data = out_data_r;
  assign out_chan.in_range  = out_inr_r;
  assign out_chan.out_side  = OSIDE_W'(out_side_r);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fire_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_PREP)
    else $error("accepted word did not enter decode");

  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result raised outside finish");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_inr_r |-> out_data_r == '0)
    else $error("out-of-range result carries data");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r < CNT_W'(IDX_W))
    else $error("divider ran past its step count");

  a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == ST_PREP && req_r == REQ_WRITE)
    else $error("store written outside a write request");

endmodule
